// ===== hdl/assert_macros.svh =====
// Assertion helpers for the concurrent checks in the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`else

`define ASSERT_SAME(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/hypm_pkg.sv =====
package hypm_pkg;

   // Leg width; the root comes out at the same width.
   localparam int LEG_BITS  = 16;
   localparam int SUM_BITS  = 2 * LEG_BITS;
   localparam int REM_BITS  = LEG_BITS + 1;
   localparam int WORK_BITS = REM_BITS + 2;
   localparam int CNT_BITS  = $clog2(LEG_BITS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT
   } state_type;

   typedef struct packed {
      logic                done;
      logic [SUM_BITS-1:0] sum;
   } sumsq_status_type;

   typedef struct packed {
      logic                done;
      logic [LEG_BITS-1:0] root;
   } sqrt_status_type;

endpackage

// ===== hdl/hypm_sumsq.sv =====
module hypm_sumsq
   import hypm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic [LEG_BITS-2:0] leg_a,
   input  logic [LEG_BITS-2:0] leg_b,
   output sumsq_status_type    status
);

   logic [LEG_BITS-2:0] leg_a_ff, leg_a_in;
   logic [LEG_BITS-2:0] leg_b_ff, leg_b_in;
   logic [SUM_BITS-1:0] sum_ff, sum_in;
   logic                run_ff, run_in;
   logic                second_ff, second_in;
   logic                done_ff, done_in;
   logic [LEG_BITS-2:0] mul_op;
   logic [SUM_BITS-1:0] product;

   // Share one squarer: first leg a, then leg b
   assign mul_op  = second_ff ? leg_b_ff : leg_a_ff;
   assign product = SUM_BITS'(mul_op) * SUM_BITS'(mul_op);

   always_comb begin
      leg_a_in  = leg_a_ff;
      leg_b_in  = leg_b_ff;
      sum_in    = sum_ff;
      run_in    = run_ff;
      second_in = second_ff;
      done_in   = 1'b0;
      if (load) begin
         leg_a_in  = leg_a;
         leg_b_in  = leg_b;
         run_in    = 1'b1;
         second_in = 1'b0;
      end else if (run_ff) begin
         if (!second_ff) begin
            sum_in    = product;
            second_in = 1'b1;
         end else begin
            sum_in  = sum_ff + product;
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff    <= 1'b0;
         second_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         run_ff    <= run_in;
         second_ff <= second_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      leg_a_ff <= leg_a_in;
      leg_b_ff <= leg_b_in;
      sum_ff   <= sum_in;
   end

   assign status.done = done_ff;
   assign status.sum  = sum_ff;

endmodule

// ===== hdl/hypm_sqrt.sv =====
module hypm_sqrt
   import hypm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic [SUM_BITS-1:0] radicand,
   output sqrt_status_type     status
);

   logic [SUM_BITS-1:0] rad_ff, rad_in;
   logic [REM_BITS-1:0] rem_ff, rem_in;
   logic [LEG_BITS-1:0] root_ff, root_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                done_ff, done_in;
   logic [WORK_BITS-1:0] rem_shift;
   logic [WORK_BITS-1:0] trial;
   logic                 fits;

   // Bring down the next two radicand bits and test root*4+1
   assign rem_shift = {rem_ff, rad_ff[SUM_BITS-1 -: 2]};
   assign trial     = {1'b0, root_ff, 2'b01};
   assign fits      = (rem_shift >= trial);

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (load) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_BITS'(LEG_BITS);
      end else if (cnt_ff != '0) begin
         rad_in  = {rad_ff[SUM_BITS-3:0], 2'b00};
         rem_in  = fits ? REM_BITS'(rem_shift - trial) : REM_BITS'(rem_shift);
         root_in = {root_ff[LEG_BITS-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign status.done = done_ff;
   assign status.root = root_ff;

endmodule

// ===== hdl/hypotenuse_magnitude_core.sv =====
// Each accepted item passes the leg load, leg a then leg b on the shared squarer,
// the root load, the 16 steps of the bit-serial root and the result register.
// Busy holds from the accepted start to the result beat; a new item waits until then.
// An item with a zero or negative leg is taken while idle and yields no beat.
// Reset (synchronous, active high) returns the block to idle; results are never stalled.
`include "assert_macros.svh"

module hypotenuse_magnitude_core
   import hypm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [LEG_BITS-1:0] req_leg_a,
   input  logic [LEG_BITS-1:0] req_leg_b,
   output logic                rsp_valid,
   output logic [LEG_BITS-1:0] rsp_hypotenuse
);

   state_type            state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [LEG_BITS-1:0]  rsp_hyp_ff, rsp_hyp_in;
   logic                 accept;
   logic                 legs_ok;
   logic                 sumsq_load;
   logic                 sqrt_load;
   sumsq_status_type     sumsq_stat;
   sqrt_status_type      sqrt_stat;

   assign accept  = start && !busy;
   assign legs_ok = (req_leg_a != '0) && !req_leg_a[LEG_BITS-1]
                 && (req_leg_b != '0) && !req_leg_b[LEG_BITS-1];

   hypm_sumsq u_sumsq (
      .clock  (clock),
      .reset  (reset),
      .load   (sumsq_load),
      .leg_a  (req_leg_a[LEG_BITS-2:0]),
      .leg_b  (req_leg_b[LEG_BITS-2:0]),
      .status (sumsq_stat)
   );

   hypm_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .load     (sqrt_load),
      .radicand (sumsq_stat.sum),
      .status   (sqrt_stat)
   );

   // Sequence square, root and result beat; drop items with a nonpositive leg
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      rsp_hyp_in   = rsp_hyp_ff;
      sumsq_load   = 1'b0;
      sqrt_load    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && legs_ok) begin
               sumsq_load = 1'b1;
               state_in   = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (sumsq_stat.done) begin
               sqrt_load = 1'b1;
               state_in  = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (sqrt_stat.done) begin
               rsp_valid_in = 1'b1;
               rsp_hyp_in   = sqrt_stat.root;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hyp_ff <= rsp_hyp_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hypotenuse = rsp_hyp_ff;

   `ASSERT_SAME(a_beat_when_idle, clock, reset, rsp_valid, !busy)
   `ASSERT_SAME(a_beat_nonzero, clock, reset, rsp_valid, rsp_hypotenuse != '0)
   `ASSERT_NEXT(a_drop_bad_legs, clock, reset, accept && !legs_ok, !busy && !rsp_valid)
   `ASSERT_SAME(a_root_in_state, clock, reset, sqrt_stat.done, state_ff == ST_ROOT)

endmodule
